/* sv/tptr_pkg.sv */
`timescale 1ns / 1ps

package tptr_pkg;

  // fixed field widths of the request and result
  localparam int unsigned VA_WIDTH        = 16;
  localparam int unsigned PHYS_WIDTH      = 15;
  localparam int unsigned FRAME_OUT_WIDTH = 7;
  localparam int unsigned COUNT_WIDTH     = 32;

  // page reduction register: holds a shifted address and a page count up to 8191
  localparam int unsigned RED_W = 13;

  // default geometry
  localparam int unsigned TLB_DEPTH_DEF    = 16;
  localparam int unsigned PAGE_COUNT_DEF   = 256;
  localparam int unsigned FRAME_COUNT_DEF  = 128;
  localparam int unsigned OFFSET_WIDTH_DEF = 8;

  typedef enum logic [1:0] {
    TLB_NOP,
    TLB_DROP,
    TLB_FILL,
    TLB_SHIFT
  } tlb_op_e;

  typedef enum logic [1:0] {
    OUT_TLB_HIT = 2'd0,
    OUT_PT_HIT  = 2'd1,
    OUT_FAULT   = 2'd2
  } outcome_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_SCAN,
    ST_PT_CHECK,
    ST_DROP,
    ST_INSERT
  } state_e;

  typedef struct packed {
    logic valid;
    logic match;
  } tlb_status_t;

endpackage

/* sv/tptr_tlb.sv */
`timescale 1ns / 1ps

module tptr_tlb #(
  parameter int unsigned TLB_DEPTH = tptr_pkg::TLB_DEPTH_DEF,
  parameter int unsigned PAGE_W    = 8,
  parameter int unsigned FRAME_W   = 7
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tptr_pkg::tlb_op_e            op_i,
  input  logic                         cmp_frame_i,
  input  logic [$clog2(TLB_DEPTH)-1:0] idx_i,
  input  logic [PAGE_W-1:0]            page_i,
  input  logic [FRAME_W-1:0]           frame_i,
  output tptr_pkg::tlb_status_t        status_o,
  output logic [FRAME_W-1:0]           rd_frame_o
);
  import tptr_pkg::*;

  localparam int unsigned KEY_W = (PAGE_W > FRAME_W) ? PAGE_W : FRAME_W;

  logic               valid_q [TLB_DEPTH];
  logic [PAGE_W-1:0]  page_q  [TLB_DEPTH];
  logic [FRAME_W-1:0] frame_q [TLB_DEPTH];

  logic [KEY_W-1:0] slot_key;
  logic [KEY_W-1:0] ref_key;

  // the one comparator, keyed on page for lookup and on frame for drop
  always_comb begin
    if (cmp_frame_i) begin
      slot_key = KEY_W'(frame_q[idx_i]);
      ref_key  = KEY_W'(frame_i);
    end else begin
      slot_key = KEY_W'(page_q[idx_i]);
      ref_key  = KEY_W'(page_i);
    end
    status_o.valid = valid_q[idx_i];
    status_o.match = valid_q[idx_i] && (slot_key == ref_key);
  end

  assign rd_frame_o = frame_q[idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TLB_DEPTH; k++) valid_q[k] <= 1'b0;
    end else begin
      case (op_i)
        TLB_DROP: valid_q[idx_i] <= 1'b0;
        TLB_FILL: valid_q[idx_i] <= 1'b1;
        TLB_SHIFT: begin
          for (int k = 0; k < TLB_DEPTH - 1; k++) valid_q[k] <= valid_q[k+1];
          valid_q[TLB_DEPTH-1] <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      TLB_FILL: begin
        page_q[idx_i]  <= page_i;
        frame_q[idx_i] <= frame_i;
      end
      TLB_SHIFT: begin
        for (int k = 0; k < TLB_DEPTH - 1; k++) begin
          page_q[k]  <= page_q[k+1];
          frame_q[k] <= frame_q[k+1];
        end
        page_q[TLB_DEPTH-1]  <= page_i;
        frame_q[TLB_DEPTH-1] <= frame_i;
      end
      default: ;
    endcase
  end

endmodule

/* sv/tptr_tables.sv */
`timescale 1ns / 1ps

module tptr_tables #(
  parameter int unsigned PAGE_COUNT  = tptr_pkg::PAGE_COUNT_DEF,
  parameter int unsigned FRAME_COUNT = tptr_pkg::FRAME_COUNT_DEF
) (
  input  logic                           clk_i,
  // page table
  input  logic                           pm_we_i,
  input  logic [$clog2(PAGE_COUNT)-1:0]  pm_waddr_i,
  input  logic                           pm_wvalid_i,
  input  logic [$clog2(FRAME_COUNT)-1:0] pm_wframe_i,
  input  logic [$clog2(PAGE_COUNT)-1:0]  pm_raddr_i,
  output logic                           pm_rvalid_o,
  output logic [$clog2(FRAME_COUNT)-1:0] pm_rframe_o,
  // frame owners
  input  logic                           fo_we_i,
  input  logic [$clog2(FRAME_COUNT)-1:0] fo_waddr_i,
  input  logic                           fo_wvalid_i,
  input  logic [$clog2(PAGE_COUNT)-1:0]  fo_wpage_i,
  input  logic [$clog2(FRAME_COUNT)-1:0] fo_raddr_i,
  output logic                           fo_rvalid_o,
  output logic [$clog2(PAGE_COUNT)-1:0]  fo_rpage_o
);

  localparam int unsigned PW = $clog2(PAGE_COUNT);
  localparam int unsigned FW = $clog2(FRAME_COUNT);

  logic [FW:0] pm_mem [PAGE_COUNT];
  logic [PW:0] fo_mem [FRAME_COUNT];

  always_ff @(posedge clk_i) begin
    if (pm_we_i) pm_mem[pm_waddr_i] <= {pm_wvalid_i, pm_wframe_i};
    {pm_rvalid_o, pm_rframe_o} <= pm_mem[pm_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (fo_we_i) fo_mem[fo_waddr_i] <= {fo_wvalid_i, fo_wpage_i};
    {fo_rvalid_o, fo_rpage_o} <= fo_mem[fo_raddr_i];
  end

endmodule

/* sv/tlb_page_table_translator.sv */
// sequence: an accepted request does its page wrap subtractions, then the one slot comparator
//   walks the tlb for a lookup; a page table check follows a miss, and a page fault walks
//   the tlb once more to drop the reused frame before the insert
// throughput: one request at a time, busy drops with done so the next goes at its end edge
// reset: clears the tlb at once, then sweeps page table and frame owners one entry a
//   cycle with busy high; done cannot be stalled
`timescale 1ns / 1ps

module tlb_page_table_translator #(
  parameter int unsigned TLB_DEPTH    = tptr_pkg::TLB_DEPTH_DEF,
  parameter int unsigned PAGE_COUNT   = tptr_pkg::PAGE_COUNT_DEF,
  parameter int unsigned FRAME_COUNT  = tptr_pkg::FRAME_COUNT_DEF,
  parameter int unsigned OFFSET_WIDTH = tptr_pkg::OFFSET_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic [tptr_pkg::VA_WIDTH-1:0]         virt_addr_i,
  output logic                                  done_o,
  output logic [tptr_pkg::PHYS_WIDTH-1:0]       phys_addr_o,
  output logic [1:0]                            outcome_o,
  output logic [tptr_pkg::FRAME_OUT_WIDTH-1:0]  frame_out_o,
  output logic [tptr_pkg::COUNT_WIDTH-1:0]      hit_count_o,
  output logic [tptr_pkg::COUNT_WIDTH-1:0]      fault_count_o,
  output logic [tptr_pkg::COUNT_WIDTH-1:0]      access_count_o
);
  import tptr_pkg::*;

  localparam int unsigned PW    = $clog2(PAGE_COUNT);
  localparam int unsigned FW    = $clog2(FRAME_COUNT);
  localparam int unsigned TW    = $clog2(TLB_DEPTH);
  localparam int unsigned CLR_N = (PAGE_COUNT > FRAME_COUNT) ? PAGE_COUNT : FRAME_COUNT;
  localparam int unsigned CLW   = $clog2(CLR_N);

  localparam logic [TW-1:0]    LAST_SLOT  = TW'(TLB_DEPTH - 1);
  localparam logic [FW-1:0]    LAST_FRAME = FW'(FRAME_COUNT - 1);
  localparam logic [CLW-1:0]   LAST_CLR   = CLW'(CLR_N - 1);
  localparam logic [RED_W-1:0] PAGES_RED  = RED_W'(PAGE_COUNT);

  // sequencer state
  state_e state_q, state_d;
  logic [CLW-1:0]   clr_q, clr_d;
  logic [RED_W-1:0] page_red_q, page_red_d;
  logic [VA_WIDTH-1:0] va_q, va_d;
  logic [TW-1:0]    scan_q, scan_d;
  logic [FW-1:0]    frame_q, frame_d;
  logic             free_found_q, free_found_d;
  logic [TW-1:0]    free_idx_q, free_idx_d;
  logic [FW-1:0]    next_frame_q, next_frame_d;

  // running counts
  logic [COUNT_WIDTH-1:0] hits_q, hits_d;
  logic [COUNT_WIDTH-1:0] faults_q, faults_d;
  logic [COUNT_WIDTH-1:0] accesses_q, accesses_d;

  // result registers
  logic                       done_q, done_d;
  logic [PHYS_WIDTH-1:0]      phys_q, phys_d;
  outcome_e                   outcome_q, outcome_d;
  logic [FRAME_OUT_WIDTH-1:0] frame_out_q, frame_out_d;

  // tlb control
  tlb_op_e     tlb_op;
  logic        cmp_frame;
  logic [TW-1:0] tlb_idx;
  tlb_status_t tlb_status;
  logic [FW-1:0] tlb_frame;

  // table ports
  logic          pm_we, pm_wvalid, pm_rvalid;
  logic [PW-1:0] pm_waddr;
  logic [FW-1:0] pm_wframe, pm_rframe;
  logic          fo_we, fo_wvalid, fo_rvalid;
  logic [FW-1:0] fo_waddr;
  logic [PW-1:0] fo_rpage;

  logic [PW-1:0] page;
  logic          finish;
  outcome_e      fin_outcome;
  logic [FW-1:0] fin_frame;
  logic [31:0]   fin_ext;
  logic [31:0]   phys_w;

  assign page = page_red_q[PW-1:0];

  tptr_tlb #(
    .TLB_DEPTH (TLB_DEPTH),
    .PAGE_W    (PW),
    .FRAME_W   (FW)
  ) u_tlb (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (tlb_op),
    .cmp_frame_i (cmp_frame),
    .idx_i       (tlb_idx),
    .page_i      (page),
    .frame_i     (frame_q),
    .status_o    (tlb_status),
    .rd_frame_o  (tlb_frame)
  );

  // page table read stays on the current page, owner read on the next fifo frame
  tptr_tables #(
    .PAGE_COUNT  (PAGE_COUNT),
    .FRAME_COUNT (FRAME_COUNT)
  ) u_tables (
    .clk_i       (clk_i),
    .pm_we_i     (pm_we),
    .pm_waddr_i  (pm_waddr),
    .pm_wvalid_i (pm_wvalid),
    .pm_wframe_i (pm_wframe),
    .pm_raddr_i  (page),
    .pm_rvalid_o (pm_rvalid),
    .pm_rframe_o (pm_rframe),
    .fo_we_i     (fo_we),
    .fo_waddr_i  (fo_waddr),
    .fo_wvalid_i (fo_wvalid),
    .fo_wpage_i  (page),
    .fo_raddr_i  (next_frame_q),
    .fo_rvalid_o (fo_rvalid),
    .fo_rpage_o  (fo_rpage)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      scan_q       <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      next_frame_q <= '0;
      hits_q       <= '0;
      faults_q     <= '0;
      accesses_q   <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      scan_q       <= scan_d;
      free_found_q <= free_found_d;
      free_idx_q   <= free_idx_d;
      next_frame_q <= next_frame_d;
      hits_q       <= hits_d;
      faults_q     <= faults_d;
      accesses_q   <= accesses_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_red_q  <= page_red_d;
    va_q        <= va_d;
    frame_q     <= frame_d;
    phys_q      <= phys_d;
    outcome_q   <= outcome_d;
    frame_out_q <= frame_out_d;
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    page_red_d   = page_red_q;
    va_d         = va_q;
    scan_d       = scan_q;
    frame_d      = frame_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    next_frame_d = next_frame_q;
    hits_d       = hits_q;
    faults_d     = faults_q;
    accesses_d   = accesses_q;
    done_d       = 1'b0;
    phys_d       = phys_q;
    outcome_d    = outcome_q;
    frame_out_d  = frame_out_q;

    tlb_op    = TLB_NOP;
    cmp_frame = 1'b0;
    tlb_idx   = scan_q;

    pm_we     = 1'b0;
    pm_waddr  = page;
    pm_wvalid = 1'b0;
    pm_wframe = frame_q;
    fo_we     = 1'b0;
    fo_waddr  = next_frame_q;
    fo_wvalid = 1'b1;

    finish      = 1'b0;
    fin_outcome = OUT_FAULT;
    fin_frame   = frame_q;

    unique case (state_q)
      ST_CLEAR: begin
        // invalidate one page table entry and one owner entry per cycle, each until its table is covered
        pm_we     = ({1'b0, clr_q} < (CLW + 1)'(PAGE_COUNT));
        pm_waddr  = clr_q[PW-1:0];
        fo_we     = ({1'b0, clr_q} < (CLW + 1)'(FRAME_COUNT));
        fo_waddr  = clr_q[FW-1:0];
        fo_wvalid = 1'b0;
        if (clr_q == LAST_CLR) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + CLW'(1);
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          va_d       = virt_addr_i;
          page_red_d = RED_W'(virt_addr_i >> OFFSET_WIDTH);
          state_d    = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        // page number wraps modulo the table size
        if (page_red_q >= PAGES_RED) begin
          page_red_d = page_red_q - PAGES_RED;
        end else begin
          scan_d  = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // lowest matching slot wins
        if (tlb_status.match) begin
          finish      = 1'b1;
          fin_frame   = tlb_frame;
          fin_outcome = OUT_TLB_HIT;
          hits_d      = hits_q + COUNT_WIDTH'(1);
          state_d     = ST_IDLE;
        end else if (scan_q == LAST_SLOT) begin
          state_d = ST_PT_CHECK;
        end else begin
          scan_d = scan_q + TW'(1);
        end
      end
      ST_PT_CHECK: begin
        if (pm_rvalid) begin
          finish      = 1'b1;
          fin_frame   = pm_rframe;
          fin_outcome = OUT_PT_HIT;
          state_d     = ST_IDLE;
        end else begin
          // fault: unmap the old owner of the fifo frame and claim it
          frame_d      = next_frame_q;
          pm_we        = fo_rvalid;
          pm_waddr     = fo_rpage;
          pm_wvalid    = 1'b0;
          fo_we        = 1'b1;
          scan_d       = '0;
          free_found_d = 1'b0;
          free_idx_d   = '0;
          state_d      = ST_DROP;
        end
      end
      ST_DROP: begin
        // free slots naming the reused frame, note the first free slot afterwards
        cmp_frame = 1'b1;
        if (tlb_status.match) tlb_op = TLB_DROP;
        if (!free_found_q && (!tlb_status.valid || tlb_status.match)) begin
          free_found_d = 1'b1;
          free_idx_d   = scan_q;
        end
        if (scan_q == LAST_SLOT) begin
          state_d = ST_INSERT;
        end else begin
          scan_d = scan_q + TW'(1);
        end
      end
      ST_INSERT: begin
        tlb_idx   = free_idx_q;
        tlb_op    = free_found_q ? TLB_FILL : TLB_SHIFT;
        pm_we     = 1'b1;
        pm_wvalid = 1'b1;
        if (next_frame_q == LAST_FRAME) begin
          next_frame_d = '0;
        end else begin
          next_frame_d = next_frame_q + FW'(1);
        end
        faults_d    = faults_q + COUNT_WIDTH'(1);
        finish      = 1'b1;
        fin_frame   = frame_q;
        fin_outcome = OUT_FAULT;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    fin_ext = 32'(fin_frame);
    phys_w  = (fin_ext << OFFSET_WIDTH) |
              (32'(va_q) & ((32'd1 << OFFSET_WIDTH) - 32'd1));

    if (finish) begin
      accesses_d  = accesses_q + COUNT_WIDTH'(1);
      done_d      = 1'b1;
      phys_d      = phys_w[PHYS_WIDTH-1:0];
      outcome_d   = fin_outcome;
      frame_out_d = fin_ext[FRAME_OUT_WIDTH-1:0];
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign phys_addr_o    = phys_q;
  assign outcome_o      = outcome_q;
  assign frame_out_o    = frame_out_q;
  // counters change only at a completion, so they hold the values of the last request
  assign hit_count_o    = hits_q;
  assign fault_count_o  = faults_q;
  assign access_count_o = accesses_q;

endmodule

/* dv/tptr_xlat_checker.sv */
`timescale 1ns / 1ps

module tptr_xlat_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic                                 busy_i,
  input  logic [tptr_pkg::VA_WIDTH-1:0]        virt_addr_i,
  input  logic                                 done_i,
  input  logic [tptr_pkg::PHYS_WIDTH-1:0]      phys_addr_i,
  input  logic [1:0]                           outcome_i,
  input  logic [tptr_pkg::FRAME_OUT_WIDTH-1:0] frame_out_i,
  input  logic [tptr_pkg::COUNT_WIDTH-1:0]     hit_count_i,
  input  logic [tptr_pkg::COUNT_WIDTH-1:0]     fault_count_i,
  input  logic [tptr_pkg::COUNT_WIDTH-1:0]     access_count_i,
  output int                                   pending_o,
  output int                                   errors_o
);

  import tptr_pkg::*;

  localparam int unsigned TLB_N    = TLB_DEPTH_DEF;
  localparam int unsigned N_PAGES  = PAGE_COUNT_DEF;
  localparam int unsigned N_FRAMES = FRAME_COUNT_DEF;
  localparam int unsigned OFF_W    = OFFSET_WIDTH_DEF;
  localparam int unsigned PG_W     = $clog2(N_PAGES);
  localparam int unsigned FR_W     = $clog2(N_FRAMES);

  typedef struct packed {
    logic            valid;
    logic [PG_W-1:0] page;
    logic [FR_W-1:0] frame;
  } tlb_slot_t;

  typedef struct {
    logic [PHYS_WIDTH-1:0]      phys;
    outcome_e                   outcome;
    logic [FRAME_OUT_WIDTH-1:0] frame;
    logic [COUNT_WIDTH-1:0]     hits;
    logic [COUNT_WIDTH-1:0]     faults;
    logic [COUNT_WIDTH-1:0]     accesses;
  } xlat_result_t;

  // mirror of the translator state
  logic                   page_ok  [N_PAGES];
  logic [FR_W-1:0]        page_frm [N_PAGES];
  logic                   owner_ok [N_FRAMES];
  logic [PG_W-1:0]        owner_pg [N_FRAMES];
  tlb_slot_t              tlb_slots [TLB_N];
  logic [FR_W-1:0]        next_frm;
  logic [COUNT_WIDTH-1:0] hits_seen;
  logic [COUNT_WIDTH-1:0] faults_seen;
  logic [COUNT_WIDTH-1:0] accesses_seen;

  xlat_result_t translations_due [$];
  int           mismatch_count;

  function automatic void clear_translator();
    int i;
    for (i = 0; i < N_PAGES; i++) begin
      page_ok[i]  = 1'b0;
      page_frm[i] = '0;
    end
    for (i = 0; i < N_FRAMES; i++) begin
      owner_ok[i] = 1'b0;
      owner_pg[i] = '0;
    end
    for (i = 0; i < TLB_N; i++) tlb_slots[i] = '0;
    next_frm      = '0;
    hits_seen     = '0;
    faults_seen   = '0;
    accesses_seen = '0;
  endfunction

  function automatic xlat_result_t translate_addr(input logic [VA_WIDTH-1:0] va);
    xlat_result_t    r;
    logic [PG_W-1:0] pg;
    logic [FR_W-1:0] frm;
    logic [OFF_W-1:0] offs;
    logic            found;
    logic            placed;
    int              k;
    pg     = PG_W'((32'(va) >> OFF_W) % N_PAGES);
    offs   = va[OFF_W-1:0];
    frm    = '0;
    found  = 1'b0;
    placed = 1'b0;
    accesses_seen++;
    // lowest matching slot wins
    for (k = 0; k < TLB_N; k++) begin
      if (!found && tlb_slots[k].valid && tlb_slots[k].page == pg) begin
        frm   = tlb_slots[k].frame;
        found = 1'b1;
      end
    end
    if (found) begin
      hits_seen++;
      r.outcome = OUT_TLB_HIT;
    end else if (page_ok[pg]) begin
      frm       = page_frm[pg];
      r.outcome = OUT_PT_HIT;
    end else begin
      frm = next_frm;
      // reused frame: old owner loses its mapping and its tlb slots
      if (owner_ok[frm]) page_ok[owner_pg[frm]] = 1'b0;
      for (k = 0; k < TLB_N; k++) begin
        if (tlb_slots[k].valid && tlb_slots[k].frame == frm) tlb_slots[k].valid = 1'b0;
      end
      page_ok[pg]   = 1'b1;
      page_frm[pg]  = frm;
      owner_ok[frm] = 1'b1;
      owner_pg[frm] = pg;
      faults_seen++;
      next_frm = FR_W'((32'(frm) + 1) % N_FRAMES);
      for (k = 0; k < TLB_N; k++) begin
        if (!placed && !tlb_slots[k].valid) begin
          tlb_slots[k] = '{valid: 1'b1, page: pg, frame: frm};
          placed       = 1'b1;
        end
      end
      if (!placed) begin
        for (k = 1; k < TLB_N; k++) tlb_slots[k-1] = tlb_slots[k];
        tlb_slots[TLB_N-1] = '{valid: 1'b1, page: pg, frame: frm};
      end
      r.outcome = OUT_FAULT;
    end
    r.phys     = PHYS_WIDTH'((32'(frm) << OFF_W) | 32'(offs));
    r.frame    = FRAME_OUT_WIDTH'(frm);
    r.hits     = hits_seen;
    r.faults   = faults_seen;
    r.accesses = accesses_seen;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    xlat_result_t want;
    if (!rst_ni) begin
      clear_translator();
      translations_due.delete();
      mismatch_count = 0;
    end else begin
      // retire before accepting: a done in the same cycle belongs to an older request
      if (done_i) begin
        if (translations_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result with no request outstanding, phys 0x%0h", $time, phys_addr_i);
        end else begin
          want = translations_due.pop_front();
          check_field("phys_addr", 32'(want.phys), 32'(phys_addr_i));
          check_field("outcome", 32'(want.outcome), 32'(outcome_i));
          check_field("frame_out", 32'(want.frame), 32'(frame_out_i));
          check_field("hit_count", want.hits, hit_count_i);
          check_field("fault_count", want.faults, fault_count_i);
          check_field("access_count", want.accesses, access_count_i);
        end
      end
      if (start_i && !busy_i) translations_due.push_back(translate_addr(virt_addr_i));
    end
    pending_o = translations_due.size();
    errors_o  = mismatch_count;
  end

endmodule

/* dv/tlb_page_table_translator_tb.sv */
`timescale 1ns / 1ps

module tlb_page_table_translator_tb;

  import tptr_pkg::*;

  // cycles with no request accepted and no result seen before giving up;
  // covers the reset sweep of the page table and a worst-case fault many times over
  localparam int IDLE_LIMIT   = 4000;
  localparam int RAND_ITEMS   = 780;
  // no idling from here on
  localparam int STEADY_FROM  = 650;
  localparam int HOT_N        = 8;
  localparam int WARM_SPAN    = 48;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [VA_WIDTH-1:0]        virt_addr = '0;
  logic                       done;
  logic [PHYS_WIDTH-1:0]      phys_addr;
  logic [1:0]                 outcome;
  logic [FRAME_OUT_WIDTH-1:0] frame_out;
  logic [COUNT_WIDTH-1:0]     hit_count;
  logic [COUNT_WIDTH-1:0]     fault_count;
  logic [COUNT_WIDTH-1:0]     access_count;
  int                         pending;
  int                         errors;
  int                         idle_cycles = 0;

  always #4 clk = ~clk;

  tlb_page_table_translator dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_o         (busy),
    .virt_addr_i    (virt_addr),
    .done_o         (done),
    .phys_addr_o    (phys_addr),
    .outcome_o      (outcome),
    .frame_out_o    (frame_out),
    .hit_count_o    (hit_count),
    .fault_count_o  (fault_count),
    .access_count_o (access_count)
  );

  tptr_xlat_checker checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .virt_addr_i    (virt_addr),
    .done_i         (done),
    .phys_addr_i    (phys_addr),
    .outcome_i      (outcome),
    .frame_out_i    (frame_out),
    .hit_count_i    (hit_count),
    .fault_count_i  (fault_count),
    .access_count_i (access_count),
    .pending_o      (pending),
    .errors_o       (errors)
  );

  // watchdog: any accepted request or result restarts the count
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no progress for %0d cycles", IDLE_LIMIT);
      $display("** tlb_page_table_translator: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // issue one request, optionally after an idle burst; called and returns at a
  // falling edge with start still high, so back-to-back requests never toggle it
  task automatic send_request(input logic [VA_WIDTH-1:0] va, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start     <= 1'b1;
    virt_addr <= va;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // hold the sender off until every outstanding translation has come back
  task automatic drain_requests();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    logic [7:0]  hot_pages [HOT_N];
    logic [7:0]  warm_base;
    logic [7:0]  pg;
    int          n;
    int          pick;
    int          gap;

    // reset held, then released on a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: offset and page extremes, then overflow the tlb
    send_request(16'h0000, 0);  // cold miss on page 0, offset 0
    send_request(16'h00FF, 0);  // tlb hit, top offset
    send_request(16'hFFFF, 0);  // fault on the last page, all ones
    send_request(16'hFF00, 2);  // tlb hit after a short gap
    // pages 1..14 fill the remaining slots, 15 and 16 shift out pages 0 and 255
    for (n = 1; n <= 16; n++) send_request({8'(n), 8'(n) ^ 8'hA5}, 0);
    send_request(16'h0042, 0);  // page 0 only in the page table now
    send_request(16'hFF80, 0);  // page 255 likewise
    send_request(16'h10AA, 0);  // page 16 still in the tlb
    send_request(16'h10AA, 3);  // repeat of the same address
    drain_requests();

    // random: mostly a drifting working set so tlb and page table hits are
    // common, with uniform addresses forcing faults and frame reuse
    for (n = 0; n < HOT_N; n++) hot_pages[n] = 8'($urandom_range(0, 255));
    warm_base = 8'($urandom_range(0, 255));
    for (n = 0; n < RAND_ITEMS; n++) begin
      if ($urandom_range(0, 15) == 0) hot_pages[$urandom_range(0, HOT_N - 1)] =
        8'($urandom_range(0, 255));
      if (n % 100 == 99) warm_base = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        pg = hot_pages[$urandom_range(0, HOT_N - 1)];
      end else if (pick < 75) begin
        pg = warm_base + 8'($urandom_range(0, WARM_SPAN - 1));
      end else begin
        pg = 8'($urandom_range(0, 255));
      end
      gap = 0;
      if (n < STEADY_FROM && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
      send_request({pg, 8'($urandom_range(0, 255))}, gap);
      // sender pauses with the block fully drained a couple of times
      if (n == 200 || n == 500) drain_requests();
    end

    // wind down: all results in, then a margin for stray strobes
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("** tlb_page_table_translator: PASSED **");
    end else begin
      $display("** tlb_page_table_translator: FAILED **");
    end
    $finish;
  end

endmodule
